@@ sv/btff_pkg.sv @@
// Shared constants and word types of the boundary-tag first-fit allocator.
package btff_pkg;

  localparam int unsigned HEAP_WORDS_DEF = 16384;

  localparam int unsigned WORD_W = 32;  // heap word
  localparam int unsigned IDX_W  = 32;  // word index, wide enough for any tag arithmetic
  localparam int unsigned BLK_W  = 16;  // index of a block inside the used heap
  localparam int unsigned NEED_W = 17;  // rounded request and heap byte count
  localparam int unsigned ADDR_W = 16;  // payload byte offset
  localparam int unsigned LIM_W  = 5;   // page limit register

  localparam logic [WORD_W-1:0] TAG_SENTINEL = 32'hCAFEBABE;
  localparam int unsigned PAGE_BYTES     = 4096;
  localparam int unsigned PAGE_WORDS     = PAGE_BYTES / 4;
  localparam int unsigned MAX_PAGES_ADDR = 16;

  localparam logic [LIM_W-1:0] LIM_RESET = 5'd16;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] req_bytes;
    logic [ADDR_W-1:0] free_addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] payload_addr;
    logic              ok;
  } res_t;

endpackage

@@ sv/btff_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
module btff_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/btff_ctrl.sv @@
// Sequencer that walks, splits, grows and merges blocks in the heap memory.
module btff_ctrl #(
  parameter int unsigned HEAP_WORDS = btff_pkg::HEAP_WORDS_DEF,
  localparam int unsigned AW        = $clog2(HEAP_WORDS)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [btff_pkg::LIM_W-1:0] limit_i,
  input  logic                       req_valid_i,
  input  btff_pkg::req_t             req_i,
  output logic                       busy_o,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output btff_pkg::res_t             res_o,
  output logic                       mem_we_o,
  output logic [AW-1:0]              mem_addr_o,
  output logic [btff_pkg::WORD_W-1:0] mem_wdata_o,
  input  logic [btff_pkg::WORD_W-1:0] mem_rdata_i
);
  import btff_pkg::*;

  localparam int unsigned MEM_PAGES = HEAP_WORDS / 1024;
  localparam int unsigned MAX_PAGES = (MEM_PAGES < MAX_PAGES_ADDR) ? MEM_PAGES : MAX_PAGES_ADDR;

  typedef enum logic [22:0] {
    S_IDLE  = 23'h000001,
    S_INIT0 = 23'h000002,
    S_INIT1 = 23'h000004,
    S_INIT2 = 23'h000008,
    S_INIT3 = 23'h000010,
    S_RDCUR = 23'h000020,
    S_SCAN  = 23'h000040,
    S_PLACE = 23'h000080,
    S_PUSED = 23'h000100,
    S_GROW  = 23'h000200,
    S_GEPI  = 23'h000400,
    S_M0    = 23'h000800,
    S_MP    = 23'h001000,
    S_MB    = 23'h002000,
    S_MN    = 23'h004000,
    S_MPP   = 23'h008000,
    S_MW    = 23'h010000,
    S_ARD   = 23'h020000,
    S_AGET  = 23'h040000,
    S_FCHK  = 23'h080000,
    S_WHDR  = 23'h100000,
    S_WFTR  = 23'h200000,
    S_FIN   = 23'h400000
  } state_e;

  state_e state_q, state_d, ret_q, ret_d, mret_q, mret_d;
  logic              started_q, started_d;
  logic [NEED_W-1:0] used_q, used_d;
  logic [NEED_W-1:0] need_q, need_d;
  logic [NEED_W-1:0] grow_q, grow_d;
  logic [BLK_W-1:0]  cur_q, cur_d;
  logic              chk_q, chk_d;
  logic [WORD_W-1:0] h_q, h_d;
  logic [IDX_W-1:0]  wx_q, wx_d;
  logic [WORD_W-1:0] wv_q, wv_d;
  logic [BLK_W-1:0]  mb_q, mb_d;
  logic [BLK_W-1:0]  mp_q, mp_d;
  logic              pval_q, pval_d;
  logic              nval_q, nval_d;
  logic [WORD_W-1:0] hb_q, hb_d;
  logic [WORD_W-1:0] hn_q, hn_d;
  logic [WORD_W-1:0] hp_q, hp_d;
  logic [BLK_W-1:0]  fh_q, fh_d;
  res_t              res_q, res_d;
  logic              rd_oob_q;

  logic              acc_we;
  logic [IDX_W-1:0]  acc_idx;
  logic [WORD_W-1:0] acc_wdata;
  logic              acc_oob;
  logic [WORD_W-1:0] rdat;
  logic [BLK_W-1:0]  epi;
  logic [IDX_W-1:0]  epi_w;
  logic [LIM_W-1:0]  pages;
  logic [NEED_W-1:0] cap;
  logic [NEED_W-1:0] nreq;
  logic [IDX_W-1:0]  n_scan;
  logic [WORD_W-1:0] need_w;
  logic [WORD_W-1:0] s_cur;
  logic              do_split;
  logic [WORD_W-1:0] s_rem;
  logic [IDX_W-1:0]  nb;
  logic [BLK_W-1:0]  cp1;
  logic [ADDR_W-1:0] ret_addr;
  logic [NEED_W-1:0] g_sum;
  logic [NEED_W-1:0] grow;
  logic [NEED_W:0]   grown;
  logic [NEED_W-1:0] nu;
  logic [IDX_W-1:0]  p_dist;
  logic [IDX_W-1:0]  n_mrg;
  logic [IDX_W-1:0]  f_end;
  logic [WORD_W-1:0] bp, bb, bn;
  logic              pf, nf;
  logic [BLK_W-1:0]  fa_word;

  // A word past the end of the memory reads as zero and a write there is dropped.
  assign acc_oob     = acc_idx >= IDX_W'(HEAP_WORDS);
  assign mem_we_o    = acc_we && !acc_oob;
  assign mem_addr_o  = acc_idx[AW-1:0];
  assign mem_wdata_o = acc_wdata;
  assign rdat        = rd_oob_q ? '0 : mem_rdata_i;

  assign epi    = BLK_W'(used_q >> 2) - BLK_W'(1);
  assign epi_w  = IDX_W'(epi);
  assign pages  = (limit_i > LIM_W'(MAX_PAGES)) ? LIM_W'(MAX_PAGES) : limit_i;
  assign cap    = NEED_W'({pages, 12'b0});
  assign nreq   = NEED_W'(req_i.req_bytes) + NEED_W'(7);
  assign n_scan = IDX_W'(cur_q) + (rdat >> 2) + IDX_W'(2);

  assign need_w   = WORD_W'(need_q);
  assign s_cur    = h_q & ~WORD_W'(1);
  assign do_split = s_cur >= need_w + WORD_W'(16);
  assign s_rem    = s_cur - need_w - WORD_W'(8);
  assign nb       = IDX_W'(cur_q) + (need_w >> 2) + IDX_W'(2);
  assign cp1      = cur_q + BLK_W'(1);
  assign ret_addr = ADDR_W'({cp1, 2'b00});

  assign g_sum = need_q + NEED_W'(PAGE_BYTES + 7);
  assign grow  = {g_sum[NEED_W-1:12], 12'b0};
  assign grown = {1'b0, used_q} + {1'b0, grow};
  assign nu    = used_q + grow_q;

  assign p_dist = (rdat >> 2) + IDX_W'(2);
  assign n_mrg  = IDX_W'(mb_q) + (rdat >> 2) + IDX_W'(2);
  assign f_end  = IDX_W'(fh_q) + (rdat >> 2) + IDX_W'(1);
  assign bp     = hp_q & ~WORD_W'(1);
  assign bb     = hb_q & ~WORD_W'(1);
  assign bn     = hn_q & ~WORD_W'(1);
  assign pf     = pval_q && !hp_q[0];
  assign nf     = nval_q && !hn_q[0];
  assign fa_word = BLK_W'(req_i.free_addr >> 2) - BLK_W'(1);

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    mret_d    = mret_q;
    started_d = started_q;
    used_d    = used_q;
    need_d    = need_q;
    grow_d    = grow_q;
    cur_d     = cur_q;
    chk_d     = chk_q;
    h_d       = h_q;
    wx_d      = wx_q;
    wv_d      = wv_q;
    mb_d      = mb_q;
    mp_d      = mp_q;
    pval_d    = pval_q;
    nval_d    = nval_q;
    hb_d      = hb_q;
    hn_d      = hn_q;
    hp_d      = hp_q;
    fh_d      = fh_q;
    res_d     = res_q;
    acc_we    = 1'b0;
    acc_idx   = IDX_W'(cur_q);
    acc_wdata = wv_q;

    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          res_d = '0;
          if (req_i.op == OP_FREE) begin
            fh_d = fa_word;
            if (req_i.free_addr == '0) begin
              res_d.ok = 1'b1;
              state_d  = S_FIN;
            end else if (!started_q || (req_i.free_addr[2:0] != 3'b000)) begin
              state_d = S_FIN;
            end else begin
              acc_idx = IDX_W'(fa_word);
              state_d = S_FCHK;
            end
          end else begin
            need_d = {nreq[NEED_W-1:3], 3'b000};
            cur_d  = BLK_W'(1);
            chk_d  = 1'b0;
            if (req_i.req_bytes == '0) begin
              state_d = S_FIN;
            end else if (!started_q) begin
              state_d = (pages == '0) ? S_FIN : S_INIT0;
            end else begin
              state_d = S_RDCUR;
            end
          end
        end
      end

      // A fresh heap is one free block between the two magic words.
      S_INIT0: begin
        acc_we    = 1'b1;
        acc_idx   = '0;
        acc_wdata = TAG_SENTINEL;
        state_d   = S_INIT1;
      end
      S_INIT1: begin
        acc_we    = 1'b1;
        acc_idx   = IDX_W'(1);
        acc_wdata = WORD_W'(PAGE_BYTES - 16);
        state_d   = S_INIT2;
      end
      S_INIT2: begin
        acc_we    = 1'b1;
        acc_idx   = IDX_W'(PAGE_WORDS - 2);
        acc_wdata = WORD_W'(PAGE_BYTES - 16);
        state_d   = S_INIT3;
      end
      S_INIT3: begin
        acc_we    = 1'b1;
        acc_idx   = IDX_W'(PAGE_WORDS - 1);
        acc_wdata = TAG_SENTINEL;
        used_d    = NEED_W'(PAGE_BYTES);
        started_d = 1'b1;
        state_d   = S_RDCUR;
      end

      S_RDCUR: begin
        acc_idx = IDX_W'(cur_q);
        state_d = S_SCAN;
      end

      // One header arrives each cycle while the next one is fetched.
      S_SCAN: begin
        if (chk_q && (rdat == TAG_SENTINEL)) begin
          state_d = S_GROW;
        end else if (!rdat[0] && ((rdat & ~WORD_W'(1)) >= need_w)) begin
          h_d     = rdat;
          state_d = S_PLACE;
        end else if (n_scan > epi_w) begin
          state_d = S_GROW;
        end else begin
          cur_d   = BLK_W'(n_scan);
          chk_d   = 1'b1;
          acc_idx = n_scan;
        end
      end

      S_PLACE: begin
        res_d.payload_addr = ret_addr;
        res_d.ok           = ret_addr != '0;
        if (do_split) begin
          wx_d  = nb;
          wv_d  = s_rem;
          ret_d = S_PUSED;
        end else begin
          wx_d  = IDX_W'(cur_q);
          wv_d  = h_q | WORD_W'(1);
          ret_d = S_FIN;
        end
        state_d = S_WHDR;
      end

      S_PUSED: begin
        wx_d    = IDX_W'(cur_q);
        wv_d    = need_w | WORD_W'(1);
        ret_d   = S_FIN;
        state_d = S_WHDR;
      end

      // The old epilogue becomes the header of the new free space.
      S_GROW: begin
        if (grown > {1'b0, cap}) begin
          res_d   = '0;
          state_d = S_FIN;
        end else begin
          grow_d  = grow;
          wx_d    = epi_w;
          wv_d    = WORD_W'(grow) - WORD_W'(8);
          mb_d    = epi;
          ret_d   = S_GEPI;
          state_d = S_WHDR;
        end
      end

      S_GEPI: begin
        acc_we    = 1'b1;
        acc_idx   = IDX_W'(BLK_W'(nu >> 2) - BLK_W'(1));
        acc_wdata = TAG_SENTINEL;
        used_d    = nu;
        mret_d    = S_ARD;
        state_d   = S_M0;
      end

      // Merge: fetch the footer before the block, its header, then the neighbours.
      S_M0: begin
        acc_idx = IDX_W'(mb_q) - IDX_W'(1);
        state_d = S_MP;
      end
      S_MP: begin
        pval_d  = (rdat != TAG_SENTINEL) && (p_dist <= IDX_W'(mb_q));
        mp_d    = mb_q - BLK_W'(p_dist);
        acc_idx = IDX_W'(mb_q);
        state_d = S_MB;
      end
      S_MB: begin
        hb_d = rdat;
        if (n_mrg <= epi_w) begin
          acc_idx = n_mrg;
          state_d = S_MN;
        end else begin
          nval_d = 1'b0;
          if (pval_q) begin
            acc_idx = IDX_W'(mp_q);
            state_d = S_MPP;
          end else begin
            state_d = S_MW;
          end
        end
      end
      S_MN: begin
        hn_d   = rdat;
        nval_d = rdat != TAG_SENTINEL;
        if (pval_q) begin
          acc_idx = IDX_W'(mp_q);
          state_d = S_MPP;
        end else begin
          state_d = S_MW;
        end
      end
      S_MPP: begin
        hp_d    = rdat;
        state_d = S_MW;
      end
      S_MW: begin
        ret_d = mret_q;
        cur_d = pf ? mp_q : mb_q;
        if (pf && nf) begin
          wx_d    = IDX_W'(mp_q);
          wv_d    = bp + bb + bn + WORD_W'(16);
          state_d = S_WHDR;
        end else if (pf) begin
          wx_d    = IDX_W'(mp_q);
          wv_d    = bp + bb + WORD_W'(8);
          state_d = S_WHDR;
        end else if (nf) begin
          wx_d    = IDX_W'(mb_q);
          wv_d    = bb + bn + WORD_W'(8);
          state_d = S_WHDR;
        end else begin
          state_d = mret_q;
        end
      end

      S_ARD: begin
        acc_idx = IDX_W'(cur_q);
        state_d = S_AGET;
      end
      S_AGET: begin
        h_d     = rdat;
        state_d = S_PLACE;
      end

      S_FCHK: begin
        if (f_end >= epi_w) begin
          state_d = S_FIN;
        end else begin
          res_d.ok = 1'b1;
          wx_d     = IDX_W'(fh_q);
          wv_d     = rdat & ~WORD_W'(1);
          mb_d     = fh_q;
          mret_d   = S_FIN;
          ret_d    = S_M0;
          state_d  = S_WHDR;
        end
      end

      // Header then footer; the footer sits one word past the payload.
      S_WHDR: begin
        acc_we    = 1'b1;
        acc_idx   = wx_q;
        acc_wdata = wv_q;
        state_d   = S_WFTR;
      end
      S_WFTR: begin
        acc_we    = 1'b1;
        acc_idx   = wx_q + (wv_q >> 2) + IDX_W'(1);
        acc_wdata = wv_q;
        state_d   = ret_q;
      end

      S_FIN: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_q     <= S_IDLE;
      mret_q    <= S_IDLE;
      started_q <= 1'b0;
      used_q    <= '0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      mret_q    <= mret_d;
      started_q <= started_d;
      used_q    <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    need_q   <= need_d;
    grow_q   <= grow_d;
    cur_q    <= cur_d;
    chk_q    <= chk_d;
    h_q      <= h_d;
    wx_q     <= wx_d;
    wv_q     <= wv_d;
    mb_q     <= mb_d;
    mp_q     <= mp_d;
    pval_q   <= pval_d;
    nval_q   <= nval_d;
    hb_q     <= hb_d;
    hn_q     <= hn_d;
    hp_q     <= hp_d;
    fh_q     <= fh_d;
    res_q    <= res_d;
    rd_oob_q <= acc_oob;
  end

  assign busy_o      = state_q != S_IDLE;
  assign res_valid_o = state_q == S_FIN;
  assign res_o       = res_q;

endmodule

@@ sv/boundary_tag_first_fit_allocator.sv @@
// Boundary-tag first-fit heap allocator: limit register, output word register and the heap.
//
//   channel  direction  word                          handshake
//   cfg      in         cfg_wdata_i (page limit)      cfg_we_i
//   in       in         op_i, req_bytes_i, free_addr_i in_valid_i / in_stall_o
//   out      out        payload_addr_o, ok_o          out_valid_o / out_stall_i
//
// An allocation walks the blocks in order and writes one more header and footer pair
// when the block is split; growing the heap merges the new space with a free last block.
// A free merges the block with its free neighbours. Both share the single heap memory port.
// The first allocation after reset also builds the heap.
// A finished word waits in the output register while the next request is taken.
module boundary_tag_first_fit_allocator #(
  parameter int unsigned HEAP_WORDS = btff_pkg::HEAP_WORDS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [btff_pkg::LIM_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [btff_pkg::ADDR_W-1:0] req_bytes_i,
  input  logic [btff_pkg::ADDR_W-1:0] free_addr_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [btff_pkg::ADDR_W-1:0] payload_addr_o,
  output logic                        ok_o
);
  import btff_pkg::*;

  localparam int unsigned AW = $clog2(HEAP_WORDS);

  logic [LIM_W-1:0]  limit_q;
  logic              busy;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  req_t              req;
  logic              out_valid_q, out_valid_d;
  res_t              out_q;
  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;

  assign req.op        = op_i;
  assign req.req_bytes = req_bytes_i;
  assign req.free_addr = free_addr_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIM_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  btff_ram #(
    .WIDTH(WORD_W),
    .DEPTH(HEAP_WORDS)
  ) u_heap (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  btff_ctrl #(
    .HEAP_WORDS(HEAP_WORDS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .limit_i    (limit_q),
    .req_valid_i(in_valid_i),
    .req_i      (req),
    .busy_o     (busy),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .mem_we_o   (mem_we),
    .mem_addr_o (mem_addr),
    .mem_wdata_o(mem_wdata),
    .mem_rdata_i(mem_rdata)
  );

  // The output register takes a new word when it is empty or being emptied.
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign in_stall_o     = busy;
  assign out_valid_o    = out_valid_q;
  assign payload_addr_o = out_q.payload_addr;
  assign ok_o           = out_q.ok;

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the boundary-tag first-fit heap allocator.
module tb_top;
  import btff_pkg::*;

  localparam int unsigned HW        = HEAP_WORDS_DEF;
  localparam int unsigned CYC_LIMIT = 3000000;

  typedef struct {
    logic              op;
    logic [ADDR_W-1:0] req_bytes;
    logic [ADDR_W-1:0] free_addr;
    logic [ADDR_W-1:0] want_addr;
    logic              want_ok;
  } request_t;

  typedef struct {
    logic [ADDR_W-1:0] payload_addr;
    logic              ok;
  } answer_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic [LIM_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              op = 1'b0;
  logic [ADDR_W-1:0] req_bytes = '0;
  logic [ADDR_W-1:0] free_addr = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ADDR_W-1:0] payload_addr;
  logic              ok;

  boundary_tag_first_fit_allocator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .op_i          (op),
    .req_bytes_i   (req_bytes),
    .free_addr_i   (free_addr),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .payload_addr_o(payload_addr),
    .ok_o          (ok)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow heap kept by the predictor.
  logic [31:0]       heap_mem [HW];
  int unsigned       used_bytes;
  bit                started;
  int unsigned       lim_pages;

  request_t          pending_q [$];
  answer_t           answer_q [$];
  logic [ADDR_W-1:0] live_q [$];
  logic [ADDR_W-1:0] freed_q [$];
  answer_t           on_bus;
  answer_t           exp_ans;
  request_t          next_req;
  int                mismatches;
  int                n_answers;
  int                hold_left;
  longint            cycles;

  function automatic logic [31:0] hp_rd(longint i);
    return (i >= 0 && i < HW) ? heap_mem[i] : 32'd0;
  endfunction

  function automatic void hp_wr(longint i, logic [31:0] v);
    if (i >= 0 && i < HW) heap_mem[i] = v;
  endfunction

  function automatic longint epi_idx();
    return longint'(used_bytes / 4) - 1;
  endfunction

  function automatic int unsigned cap_bytes();
    int unsigned p;
    p = lim_pages;
    if (p > HW / 1024) p = HW / 1024;
    if (p > MAX_PAGES_ADDR) p = MAX_PAGES_ADDR;
    return p * PAGE_BYTES;
  endfunction

  function automatic logic [31:0] blk_size(longint b);
    return hp_rd(b) & 32'hFFFF_FFFE;
  endfunction

  function automatic bit blk_free(longint b);
    return (hp_rd(b) & 32'd1) == 32'd0;
  endfunction

  function automatic void sync_footer(longint b);
    logic [31:0] h;
    h = hp_rd(b);
    hp_wr(b + longint'(blk_size(b) >> 2) + 1, h);
  endfunction

  function automatic void resize_blk(longint b, logic [31:0] s);
    hp_wr(b, s | (hp_rd(b) & 32'd1));
    sync_footer(b);
  endfunction

  function automatic void set_busy(longint b);
    hp_wr(b, hp_rd(b) | 32'd1);
    sync_footer(b);
  endfunction

  function automatic void set_idle(longint b);
    hp_wr(b, hp_rd(b) & 32'hFFFF_FFFE);
    sync_footer(b);
  endfunction

  // Neighbours are found through the boundary tags; -1 means none.
  function automatic longint blk_before(longint b);
    logic [31:0] f;
    longint      d;
    if (b == 0) return -1;
    f = hp_rd(b - 1);
    if (f == TAG_SENTINEL) return -1;
    d = longint'(f >> 2) + 2;
    if (d > b) return -1;
    return b - d;
  endfunction

  function automatic longint blk_after(longint b);
    longint n;
    n = b + longint'(hp_rd(b) >> 2) + 2;
    if (n > epi_idx()) return -1;
    if (hp_rd(n) == TAG_SENTINEL) return -1;
    return n;
  endfunction

  function automatic void carve(longint b, logic [31:0] need);
    logic [31:0] s;
    longint      nb;
    s = blk_size(b);
    if ({1'b0, s} < {1'b0, need} + 33'd16) return;
    resize_blk(b, need);
    nb = b + longint'(need >> 2) + 2;
    resize_blk(nb, s - need - 32'd8);
    set_idle(nb);
  endfunction

  function automatic longint coalesce(longint b);
    longint p, n;
    bit     pf, nf;
    p = blk_before(b);
    n = blk_after(b);
    pf = (p != -1) && blk_free(p);
    nf = (n != -1) && blk_free(n);
    if (pf && nf) begin
      resize_blk(p, blk_size(p) + blk_size(b) + blk_size(n) + 32'd16);
      set_idle(p);
      return p;
    end
    if (pf) begin
      resize_blk(p, blk_size(p) + blk_size(b) + 32'd8);
      set_idle(p);
      return p;
    end
    if (nf) begin
      resize_blk(b, blk_size(b) + blk_size(n) + 32'd8);
      set_idle(b);
    end
    return b;
  endfunction

  function automatic bit open_heap();
    if (cap_bytes() < PAGE_BYTES) return 1'b0;
    used_bytes = PAGE_BYTES;
    hp_wr(0, TAG_SENTINEL);
    resize_blk(1, PAGE_BYTES - 16);
    set_idle(1);
    hp_wr(epi_idx(), TAG_SENTINEL);
    started = 1'b1;
    return 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] predict_alloc(logic [ADDR_W-1:0] req);
    logic [31:0] need, grow;
    longint      cur, n, b;
    if (req == 0) return '0;
    if (!started && !open_heap()) return '0;
    need = (32'(req) + 32'd7) & 32'hFFFF_FFF8;
    cur = 1;
    while (1) begin
      if (blk_free(cur) && blk_size(cur) >= need) begin
        carve(cur, need);
        set_busy(cur);
        return ADDR_W'((cur + 1) * 4);
      end
      n = blk_after(cur);
      if (n == -1) break;
      cur = n;
    end
    // No block fits: grow by whole pages and merge with a free last block.
    grow = (need + 32'd8 + PAGE_BYTES - 1) & ~(PAGE_BYTES - 1);
    if (longint'(used_bytes) + longint'(grow) > longint'(cap_bytes())) return '0;
    b = epi_idx();
    resize_blk(b, grow - 32'd8);
    set_idle(b);
    used_bytes += grow;
    hp_wr(epi_idx(), TAG_SENTINEL);
    b = coalesce(b);
    carve(b, need);
    set_busy(b);
    return ADDR_W'((b + 1) * 4);
  endfunction

  function automatic logic predict_free(logic [ADDR_W-1:0] addr);
    longint h;
    if (addr == 0) return 1'b1;
    if (!started || addr[2:0] != 3'd0) return 1'b0;
    h = longint'(addr / 4) - 1;
    if (h + longint'(blk_size(h) >> 2) + 1 >= epi_idx()) return 1'b0;
    set_idle(h);
    void'(coalesce(h));
    return 1'b1;
  endfunction

  // A freed address may be freed again only while it still heads a free block.
  function automatic bit heads_free_block(logic [ADDR_W-1:0] addr);
    longint cur, h;
    h = longint'(addr / 4) - 1;
    cur = 1;
    while (cur != -1) begin
      if (cur == h) return blk_free(cur);
      cur = blk_after(cur);
    end
    return 1'b0;
  endfunction

  task automatic add_item(logic o, logic [ADDR_W-1:0] rb, logic [ADDR_W-1:0] fa);
    request_t r;
    int       idx [$];
    r.op = o;
    r.req_bytes = rb;
    r.free_addr = fa;
    if (o == OP_FREE) begin
      r.want_addr = '0;
      r.want_ok = predict_free(fa);
      idx = live_q.find_first_index(x) with (x == fa);
      if (idx.size() > 0) begin
        live_q.delete(idx[0]);
        freed_q.push_back(fa);
        if (freed_q.size() > 8) void'(freed_q.pop_front());
      end
    end else begin
      r.want_addr = predict_alloc(rb);
      r.want_ok = (r.want_addr != 0);
      if (r.want_ok) live_q.push_back(r.want_addr);
    end
    pending_q.push_back(r);
  endtask

  function automatic logic [ADDR_W-1:0] rand_size();
    int r;
    r = $urandom_range(99);
    if (r < 3) return '0;
    if (r < 70) return ADDR_W'($urandom_range(256, 1));
    if (r < 90) return ADDR_W'($urandom_range(4096, 257));
    if (r < 98) return ADDR_W'($urandom_range(20000, 4097));
    return ADDR_W'($urandom_range(65535, 20001));
  endfunction

  function automatic logic [ADDR_W-1:0] misaligned();
    logic [ADDR_W-1:0] v;
    v = ADDR_W'($urandom);
    if (v[2:0] == 3'd0) v[$urandom_range(2, 0)] = 1'b1;
    return v;
  endfunction

  task automatic add_random();
    int                r, k;
    logic [ADDR_W-1:0] a;
    r = $urandom_range(99);
    if (live_q.size() > 0 && (r < 45 || live_q.size() > 60)) begin
      add_item(OP_FREE, ADDR_W'($urandom), live_q[$urandom_range(live_q.size() - 1)]);
    end else if (r < 52) begin
      k = $urandom_range(3);
      a = '0;
      if (k == 1) a = misaligned();
      if (k == 2 && started && used_bytes < 65536) a = ADDR_W'(used_bytes);
      if (k == 3 && freed_q.size() > 0) begin
        a = freed_q[$urandom_range(freed_q.size() - 1)];
        if (a inside {live_q} || !heads_free_block(a)) a = '0;
      end
      add_item(OP_FREE, ADDR_W'($urandom), a);
    end else begin
      add_item(OP_ALLOC, rand_size(), ADDR_W'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || answer_q.size() > 0 || in_valid) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [LIM_W-1:0] v);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    lim_pages = v;
  endtask

  function automatic bit roll_idle();
    if (n_answers >= 900 && n_answers < 1150) return 1'b0;
    return $urandom_range(99) < 21;
  endfunction

  initial begin
    logic [LIM_W-1:0] limits [6];
    limits = '{5'd16, 5'd1, 5'd5, 5'd16, 5'd2, 5'd16};
    for (int i = 0; i < HW; i++) heap_mem[i] = '0;
    used_bytes = 0;
    started = 1'b0;
    lim_pages = LIM_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with a two-page limit.
    write_limit(5'd2);
    add_item(OP_FREE, 16'hFFFF, 16'd8);
    add_item(OP_FREE, 16'h0000, 16'd0);
    add_item(OP_ALLOC, 16'd0, 16'hFFFF);
    add_item(OP_ALLOC, 16'hFFFF, 16'd0);
    add_item(OP_ALLOC, 16'd1, 16'd0);
    add_item(OP_ALLOC, 16'd8, 16'd0);
    add_item(OP_ALLOC, 16'd9, 16'd0);
    add_item(OP_ALLOC, 16'd16, 16'd0);
    add_item(OP_ALLOC, 16'd4000, 16'd0);
    add_item(OP_ALLOC, 16'd40000, 16'd0);
    add_item(OP_FREE, 16'd0, live_q[1]);
    add_item(OP_FREE, 16'd0, live_q[1]);
    if (heads_free_block(freed_q[$])) add_item(OP_FREE, 16'd0, freed_q[$]);
    add_item(OP_FREE, 16'd0, 16'hFFFF);
    add_item(OP_FREE, 16'd0, 16'd12);
    add_item(OP_FREE, 16'd0, ADDR_W'(used_bytes));
    add_item(OP_ALLOC, 16'd65528, 16'd0);
    add_item(OP_ALLOC, 16'd4096, 16'd0);
    add_item(OP_FREE, 16'd0, live_q[0]);
    wait_drained();

    foreach (limits[p]) begin
      write_limit(limits[p]);
      if (p == 3) add_item(OP_ALLOC, 16'd40000, 16'd0);
      repeat (280) add_random();
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    if (answer_q.size() > 0) mismatches++;
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Sender: a word stays on the bus until it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) answer_q.push_back(on_bus);
      if (!in_valid || !in_stall) begin
        if (pending_q.size() > 0 && !roll_idle()) begin
          next_req = pending_q.pop_front();
          on_bus.payload_addr = next_req.want_addr;
          on_bus.ok = next_req.want_ok;
          in_valid  <= 1'b1;
          op        <= next_req.op;
          req_bytes <= next_req.req_bytes;
          free_addr <= next_req.free_addr;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each word, stalls at random and holds off once for a long stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word addr=%h ok=%b", $time, payload_addr, ok);
        end else begin
          exp_ans = answer_q[0];
          void'(answer_q.pop_front());
          if (payload_addr !== exp_ans.payload_addr) begin
            mismatches++;
            $display("%0t: payload_addr expected %h actual %h", $time,
                     exp_ans.payload_addr, payload_addr);
          end
          if (ok !== exp_ans.ok) begin
            mismatches++;
            $display("%0t: ok expected %b actual %b", $time, exp_ans.ok, ok);
          end
        end
        n_answers++;
        if (n_answers == 400) hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= roll_idle();
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
